/* hw/rtl/lrtr_pkg.sv */
// ----------------------------------------------------------------------------
// lrtr_pkg
// shared types and constants of the line, rectangle and triangle rasterizer
// ----------------------------------------------------------------------------
package lrtr_pkg;

   localparam int COORD_W = 8;
   localparam int KIND_W  = 3;
   localparam int PROD_W  = 2 * COORD_W;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      K_CLEAR   = 3'd0,
      K_LINE    = 3'd1,
      K_OUTLINE = 3'd2,
      K_FILL    = 3'd3,
      K_TRI     = 3'd4,
      K_READ    = 3'd5
   } req_kind_type;

   // controller to datapath commands, each a one-cycle pulse
   typedef struct packed {
      logic       clr_start;
      logic       clr_zero;
      logic       seg_start;
      logic [1:0] seg_sel;
      logic       rect_start;
      logic       rd_start;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic busy;
      logic pixel;
   } sts_type;

endpackage

/* hw/rtl/lrtr_div.sv */
// ----------------------------------------------------------------------------
// lrtr_div
// restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit a cycle
// ----------------------------------------------------------------------------
module lrtr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lrtr_pkg::PROD_W-1:0]  dividend,
   input  logic [lrtr_pkg::COORD_W-1:0] divisor,
   output logic [lrtr_pkg::PROD_W-1:0]  quotient,
   output logic                         done
);
   import lrtr_pkg::*;

   localparam int CNT_W = $clog2(PROD_W);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [PROD_W-1:0]   quo_ff;
   logic [COORD_W-1:0]  rem_ff;
   logic [COORD_W-1:0]  dsr_ff;
   logic [COORD_W:0]    shift_in;
   logic                fits_in;

   // trial subtract of the shifted remainder
   always_comb begin
      shift_in = {rem_ff, quo_ff[PROD_W-1]};
      fits_in  = shift_in >= {1'b0, dsr_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[PROD_W-2:0], fits_in};
         rem_ff <= fits_in ? COORD_W'(shift_in - {1'b0, dsr_ff}) : shift_in[COORD_W-1:0];
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* hw/rtl/lrtr_dp.sv */
// ----------------------------------------------------------------------------
// lrtr_dp
// datapath: request registers, pixel walker, divider and frame store
// ----------------------------------------------------------------------------
module lrtr_dp #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_load,
   input  logic [lrtr_pkg::KIND_W-1:0]      req_kind,
   input  logic [lrtr_pkg::REQ_DATA_W-1:0]  req_data,
   input  lrtr_pkg::cmd_type                cmd,
   output lrtr_pkg::sts_type                sts
);
   import lrtr_pkg::*;

   localparam int NPIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(NPIX);
   localparam int FULL_W = 2 * COORD_W + 1;

   typedef enum logic [2:0] {
      W_IDLE, W_CLR, W_VERT, W_MUL, W_DGO, W_DWAIT, W_PLOT, W_RECT
   } walk_state_type;

   walk_state_type      wst_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [COORD_W-1:0]  xa_ff, ya_ff, xb_ff, yb_ff, xc_ff, yc_ff;
   logic                colour_ff;

   logic [COORD_W-1:0]  cur_x_ff, cur_y_ff, end_x_ff, end_y_ff;
   logic [COORD_W-1:0]  y1_ff, span_ff, mag_ff, off_ff;
   logic                neg_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [ADDR_W-1:0]   clr_cnt_ff;
   logic                clr_val_ff;
   logic                rd_data_ff, rd_inb_ff;

   logic                mem [NPIX];

   logic [COORD_W-1:0]  sx0, sy0, sx1, sy1;
   logic [COORD_W:0]    dy_full;
   logic [COORD_W-1:0]  plot_x, plot_y, y_new;
   logic                plot_en, wr_en, wr_data;
   logic [ADDR_W-1:0]   wr_addr;
   logic [PROD_W-1:0]   quot;
   logic                div_done;

   function automatic logic on_screen(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y);
      on_screen = ({1'b0, x} < (COORD_W+1)'(SCREEN_WIDTH)) &&
                  ({1'b0, y} < (COORD_W+1)'(SCREEN_HEIGHT));
   endfunction

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
      logic [FULL_W-1:0] full;
      full = FULL_W'(y) * FULL_W'(SCREEN_WIDTH) + FULL_W'(x);
      pix_addr = full[ADDR_W-1:0];
   endfunction

   // request fields
   always_ff @(posedge clock) begin
      if (req_load) begin
         kind_ff   <= req_kind;
         xa_ff     <= req_data[7:0];
         ya_ff     <= req_data[15:8];
         xb_ff     <= req_data[23:16];
         yb_ff     <= req_data[31:24];
         xc_ff     <= req_data[39:32];
         yc_ff     <= req_data[47:40];
         colour_ff <= req_data[48];
      end
   end

   // segment endpoints for the selected edge of the shape
   always_comb begin
      sx0 = xa_ff; sy0 = ya_ff; sx1 = xb_ff; sy1 = yb_ff;
      case (kind_ff)
         K_OUTLINE: begin
            case (cmd.seg_sel)
               2'd0: begin sx0 = xa_ff; sy0 = ya_ff; sx1 = xb_ff; sy1 = ya_ff; end
               2'd1: begin sx0 = xb_ff; sy0 = ya_ff; sx1 = xb_ff; sy1 = yb_ff; end
               2'd2: begin sx0 = xb_ff; sy0 = yb_ff; sx1 = xa_ff; sy1 = yb_ff; end
               default: begin sx0 = xa_ff; sy0 = yb_ff; sx1 = xa_ff; sy1 = ya_ff; end
            endcase
         end
         K_TRI: begin
            case (cmd.seg_sel)
               2'd0: begin sx0 = xa_ff; sy0 = ya_ff; sx1 = xb_ff; sy1 = yb_ff; end
               2'd1: begin sx0 = xb_ff; sy0 = yb_ff; sx1 = xc_ff; sy1 = yc_ff; end
               default: begin sx0 = xc_ff; sy0 = yc_ff; sx1 = xa_ff; sy1 = ya_ff; end
            endcase
         end
         default: ;
      endcase
   end

   // ordered rise of the segment
   always_comb begin
      if (sx1 < sx0) dy_full = {1'b0, sy0} - {1'b0, sy1};
      else           dy_full = {1'b0, sy1} - {1'b0, sy0};
   end

   // column y from the divided slope, wrapped to eight bits
   assign y_new = neg_ff ? y1_ff - quot[COORD_W-1:0] : y1_ff + quot[COORD_W-1:0];

   // pixel walker
   always_ff @(posedge clock) begin
      if (reset) begin
         wst_ff <= W_IDLE;
      end else begin
         unique case (wst_ff)
            W_IDLE: begin
               if (cmd.clr_start) begin
                  clr_cnt_ff <= '0;
                  clr_val_ff <= cmd.clr_zero ? 1'b0 : colour_ff;
                  wst_ff     <= W_CLR;
               end else if (cmd.seg_start) begin
                  if (sx0 == sx1) begin
                     cur_x_ff <= sx0;
                     cur_y_ff <= (sy0 < sy1) ? sy0 : sy1;
                     end_y_ff <= (sy0 < sy1) ? sy1 : sy0;
                     wst_ff   <= W_VERT;
                  end else begin
                     cur_x_ff <= (sx1 < sx0) ? sx1 : sx0;
                     end_x_ff <= (sx1 < sx0) ? sx0 : sx1;
                     y1_ff    <= (sx1 < sx0) ? sy1 : sy0;
                     span_ff  <= (sx1 < sx0) ? sx0 - sx1 : sx1 - sx0;
                     neg_ff   <= dy_full[COORD_W];
                     mag_ff   <= dy_full[COORD_W] ? COORD_W'(-dy_full) : dy_full[COORD_W-1:0];
                     off_ff   <= '0;
                     wst_ff   <= W_MUL;
                  end
               end else if (cmd.rect_start) begin
                  if (xa_ff <= xb_ff && ya_ff <= yb_ff) begin
                     cur_x_ff <= xa_ff;
                     cur_y_ff <= ya_ff;
                     wst_ff   <= W_RECT;
                  end
               end
            end
            W_CLR: begin
               if (clr_cnt_ff == ADDR_W'(NPIX - 1)) wst_ff <= W_IDLE;
               else clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
            W_VERT: begin
               if (cur_y_ff == end_y_ff) wst_ff <= W_IDLE;
               else cur_y_ff <= cur_y_ff + 1'b1;
            end
            W_MUL: begin
               prod_ff <= mag_ff * off_ff;
               wst_ff  <= W_DGO;
            end
            W_DGO: begin
               wst_ff <= W_DWAIT;
            end
            W_DWAIT: begin
               if (div_done) wst_ff <= W_PLOT;
            end
            W_PLOT: begin
               if (cur_x_ff == end_x_ff) begin
                  wst_ff <= W_IDLE;
               end else begin
                  cur_x_ff <= cur_x_ff + 1'b1;
                  off_ff   <= off_ff + 1'b1;
                  wst_ff   <= W_MUL;
               end
            end
            W_RECT: begin
               if (cur_x_ff == xb_ff) begin
                  cur_x_ff <= xa_ff;
                  if (cur_y_ff == yb_ff) wst_ff <= W_IDLE;
                  else cur_y_ff <= cur_y_ff + 1'b1;
               end else begin
                  cur_x_ff <= cur_x_ff + 1'b1;
               end
            end
            default: wst_ff <= W_IDLE;
         endcase
      end
   end

   lrtr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (wst_ff == W_DGO),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .quotient (quot),
      .done     (div_done)
   );

   // write port selection
   always_comb begin
      plot_en = (wst_ff == W_VERT) || (wst_ff == W_PLOT) || (wst_ff == W_RECT);
      plot_x  = cur_x_ff;
      plot_y  = (wst_ff == W_PLOT) ? y_new : cur_y_ff;
      if (wst_ff == W_CLR) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = clr_val_ff;
      end else begin
         wr_en   = plot_en && on_screen(plot_x, plot_y);
         wr_addr = pix_addr(plot_x, plot_y);
         wr_data = 1'b1;
      end
   end

   // frame store write
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   // frame store read
   always_ff @(posedge clock) begin
      if (cmd.rd_start) begin
         rd_data_ff <= mem[pix_addr(xa_ff, ya_ff)];
         rd_inb_ff  <= on_screen(xa_ff, ya_ff);
      end
   end

   assign sts.busy  = (wst_ff != W_IDLE) || cmd.clr_start || cmd.seg_start || cmd.rect_start;
   assign sts.pixel = rd_inb_ff & rd_data_ff;

endmodule

/* hw/rtl/lrtr_ctrl.sv */
// ----------------------------------------------------------------------------
// lrtr_ctrl
// controller: request sequencing, edge list of shapes and result register
// ----------------------------------------------------------------------------
module lrtr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [lrtr_pkg::KIND_W-1:0]  req_kind,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_pixel,
   output lrtr_pkg::cmd_type            cmd,
   input  lrtr_pkg::sts_type            sts
);
   import lrtr_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_INITW, S_IDLE, S_DISP, S_SEG, S_SEGW, S_CLRW, S_RECTW, S_RDW, S_FIN
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [1:0]         seg_idx_ff, seg_idx_in;
   logic [1:0]         seg_last;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_pixel_ff, rsp_pixel_in;

   // index of the last edge of the shape
   always_comb begin
      case (kind_ff)
         K_OUTLINE: seg_last = 2'd3;
         K_TRI:     seg_last = 2'd2;
         default:   seg_last = 2'd0;
      endcase
   end

   // next state, commands and result register
   always_comb begin
      state_in     = state_ff;
      cmd_in       = '0;
      kind_in      = kind_ff;
      seg_idx_in   = seg_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in = rsp_pixel_ff;
      unique case (state_ff) inside
         S_INIT: begin
            cmd_in.clr_start = 1'b1;
            cmd_in.clr_zero  = 1'b1;
            state_in         = S_INITW;
         end
         S_INITW: begin
            if (!sts.busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_kind;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            seg_idx_in = '0;
            unique case (kind_ff) inside
               K_CLEAR: begin
                  cmd_in.clr_start = 1'b1;
                  state_in         = S_CLRW;
               end
               K_LINE, K_OUTLINE, K_TRI: state_in = S_SEG;
               K_FILL: begin
                  cmd_in.rect_start = 1'b1;
                  state_in          = S_RECTW;
               end
               K_READ: begin
                  cmd_in.rd_start = 1'b1;
                  state_in        = S_RDW;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_SEG: begin
            cmd_in.seg_start = 1'b1;
            cmd_in.seg_sel   = seg_idx_ff;
            state_in         = S_SEGW;
         end
         S_SEGW: begin
            if (!sts.busy) begin
               if (seg_idx_ff == seg_last) begin
                  state_in = S_FIN;
               end else begin
                  seg_idx_in = seg_idx_ff + 1'b1;
                  state_in   = S_SEG;
               end
            end
         end
         S_CLRW, S_RECTW: begin
            if (!sts.busy) state_in = S_FIN;
         end
         S_RDW: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = (kind_ff == K_READ) ? sts.pixel : 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cmd_ff       <= '0;
         kind_ff      <= '0;
         seg_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_pixel_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         kind_ff      <= kind_in;
         seg_idx_ff   <= seg_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_pixel  = rsp_pixel_ff;
   assign cmd        = cmd_ff;

   // an edge starts only on an idle walker
   a_seg_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEG) |-> !sts.busy)
      else $error("edge started while walker busy");

   // a finished item waits while the result register is still held and not accepted
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_FIN))
      else $error("result register overwritten");

   // only a read returns a set pixel
   a_pixel_read: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_pixel_ff) |-> (kind_ff == K_READ))
      else $error("pixel set on a non-read item");

endmodule

/* hw/rtl/line_rect_triangle_rasterizer.sv */
// ----------------------------------------------------------------------------
// line_rect_triangle_rasterizer
// draw engine over a one-bit-per-pixel frame store: clear, lines, rectangles,
// triangles and pixel read, one item at a time
// ----------------------------------------------------------------------------
// drawing: clear writes every pixel; filled rectangle one cycle per pixel, vertical
//   edge one cycle per pixel, sloped edge a multiply, a divide and a plot per column
// throughput: one item at a time; the frame store write port sets the fill rate
// reset: synchronous; a clearing pass to zero over all SCREEN_WIDTH*SCREEN_HEIGHT
//   pixels runs after reset before the first item is taken
module line_rect_triangle_rasterizer #(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // x_a[7:0], y_a, x_b, y_b, x_c, y_c, clear_colour[48], zero pad
   input  logic [lrtr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_type[2:0]
   input  logic [lrtr_pkg::KIND_W-1:0]      req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pixel_value[0], done_res[1], zero pad
   output logic [lrtr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import lrtr_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    rsp_pixel;

   lrtr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_pixel  (rsp_pixel),
      .cmd        (cmd),
      .sts        (sts)
   );

   lrtr_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_load (req_tvalid && req_tready),
      .req_kind (req_tuser),
      .req_data (req_tdata),
      .cmd      (cmd),
      .sts      (sts)
   );

   // result item: pixel and completion flag
   assign rsp_tdata = {{(RSP_DATA_W-2){1'b0}}, 1'b1, rsp_pixel};

endmodule
